// ===== design/wvtp_pkg.sv =====
// Shared types, codes and constants of the weighted virtual-runtime task picker.
`timescale 1ns / 1ps

package wvtp_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_TASKS_DEF     = 16;
	localparam int INVERSE_SHIFT_DEF = 32;

	// Field and register widths.
	localparam int FUNC_W     = 2;
	localparam int WEIGHT_W   = 17;
	localparam int SEL_W      = 4;
	localparam int STATUS_W   = 2;
	localparam int SLOT_W     = 4;
	localparam int RT_W       = 64;
	localparam int CNT_W      = 32;
	localparam int INV_W      = 32;
	localparam int DELTA_W    = 20;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// Weight that is charged the plain delta, and its shift.
	localparam int UNIT_WEIGHT = 1024;
	localparam int UNIT_SHIFT  = 10;

	// Register reset values.
	localparam logic [DELTA_W-1:0] DELTA_RESET = 20'd312342;
	localparam logic [INV_W-1:0]   NUM_RESET   = 32'hFFFF_FFFF;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_TICK   = 2'd1,
		FUNC_READ   = 2'd2,
		FUNC_NOP    = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_NO_TASKS = 2'd2,
		STAT_BAD_SLOT = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TICK_DELTA = 1'd0,
		REG_INV_NUM    = 1'd1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		SEQ_IDLE,
		SEQ_DECODE,
		SEQ_DIV,
		SEQ_SCAN_RD,
		SEQ_SCAN_CMP,
		SEQ_FETCH,
		SEQ_MUL,
		SEQ_UPDATE,
		SEQ_READ,
		SEQ_REPLY
	} seq_state_t;

	// One row of the task table.
	typedef struct packed {
		logic [RT_W-1:0]     runtime;
		logic [WEIGHT_W-1:0] weight;
		logic [INV_W-1:0]    inverse;
		logic [CNT_W-1:0]    count;
	} entry_t;

	// One result item.
	typedef struct packed {
		status_t             status;
		logic [SLOT_W-1:0]   slot;
		logic [RT_W-1:0]     runtime;
		logic [CNT_W-1:0]    count;
		logic [WEIGHT_W-1:0] weight;
	} result_t;

endpackage

// ===== design/wvtp_divider.sv =====
// Serial restoring divider that forms the inverse weight, one quotient bit per cycle.
`timescale 1ns / 1ps

module wvtp_divider (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [wvtp_pkg::INV_W-1:0]    dividend,
	input  logic [wvtp_pkg::WEIGHT_W-1:0] divisor,
	output logic                         done,
	output logic [wvtp_pkg::INV_W-1:0]    quotient
);

	localparam int QW = wvtp_pkg::INV_W;
	localparam int DW = wvtp_pkg::WEIGHT_W;
	localparam int SW = $clog2(QW);

	logic          busy_q;
	logic          done_q;
	logic [SW-1:0] step_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [QW-1:0] quo_q;

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          fits;

	// Shift the next dividend bit into the partial remainder and try the subtraction.
	// A zero divisor always fits, so the quotient comes out all ones.
	assign trial = {rem_q, quo_q[QW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = (trial >= {1'b0, dvs_q});

	// Control: busy for one step per quotient bit, then a one-cycle done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == SW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend shifts out at the top while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[QW-2:0], fits};
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== design/wvtp_task_table.sv =====
// Task table memory: one write port and one registered read port.
`timescale 1ns / 1ps

module wvtp_task_table #(
	parameter int MAX_TASKS = wvtp_pkg::MAX_TASKS_DEF
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [$clog2(MAX_TASKS)-1:0] rd_addr,
	output wvtp_pkg::entry_t             rd_data,
	input  logic                         wr_en,
	input  logic [$clog2(MAX_TASKS)-1:0] wr_addr,
	input  wvtp_pkg::entry_t             wr_data
);

	wvtp_pkg::entry_t mem [MAX_TASKS];
	wvtp_pkg::entry_t rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/weighted_vruntime_task_picker_core.sv =====
// Top level of the weighted virtual-runtime task picker: sequencer, registers and result port.
`timescale 1ns / 1ps

// The block takes one item at a time and holds in_stall high from acceptance until the result
// has been moved into the output register, which then waits for the consumer on its own. An
// insert waits on the serial divider that forms the inverse weight at one quotient bit per cycle.
// A tick first searches for the minimum runtime, reading the runtime table through its single
// read port, one slot per pass through a read state and a compare state, then fetches the
// winner, multiplies and writes it back. There is no clearing pass after reset. Configuration
// writes are taken with cfg_ready held high and
// must only be made while no item is in flight, since a tick reads tick_delta late in its run.
module weighted_vruntime_task_picker_core #(
	parameter int MAX_TASKS     = wvtp_pkg::MAX_TASKS_DEF,
	parameter int INVERSE_SHIFT = wvtp_pkg::INVERSE_SHIFT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [wvtp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wvtp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [wvtp_pkg::FUNC_W-1:0]     func,
	input  logic [wvtp_pkg::WEIGHT_W-1:0]   weight,
	input  logic [wvtp_pkg::SEL_W-1:0]      slot_select,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [wvtp_pkg::STATUS_W-1:0]   status,
	output logic [wvtp_pkg::SLOT_W-1:0]     task_slot,
	output logic [wvtp_pkg::RT_W-1:0]       virtual_runtime,
	output logic [wvtp_pkg::CNT_W-1:0]      run_count,
	output logic [wvtp_pkg::WEIGHT_W-1:0]   task_weight
);

	localparam int IW     = $clog2(MAX_TASKS);
	localparam int CW     = $clog2(MAX_TASKS + 1);
	localparam int SELW   = wvtp_pkg::SEL_W;
	localparam int CMPW   = (CW > SELW) ? CW : SELW;
	localparam int SLW    = wvtp_pkg::SLOT_W;
	localparam int RTW    = wvtp_pkg::RT_W;
	localparam int WW     = wvtp_pkg::WEIGHT_W;
	localparam int DLW    = wvtp_pkg::DELTA_W;
	localparam int IVW    = wvtp_pkg::INV_W;
	localparam int PROD_W = wvtp_pkg::DELTA_W + wvtp_pkg::INV_W;

	wvtp_pkg::seq_state_t state_q, state_d;

	logic [CW-1:0]      count_q;
	logic [DLW-1:0]     tick_delta_q;
	logic [IVW-1:0]     inv_num_q;

	wvtp_pkg::func_t    func_q;
	logic [WW-1:0]      weight_q;
	logic [SELW-1:0]    sel_q;
	logic [IW-1:0]      idx_q;
	logic [IW-1:0]      best_q;
	logic [RTW-1:0]     best_rt_q;
	logic [PROD_W-1:0]  prod_q;
	wvtp_pkg::result_t  res_q;
	wvtp_pkg::result_t  out_q;
	logic               out_valid_q;

	logic               tbl_rd_en;
	logic [IW-1:0]      tbl_rd_addr;
	wvtp_pkg::entry_t   tbl_rd_data;
	logic               tbl_wr_en;
	logic [IW-1:0]      tbl_wr_addr;
	wvtp_pkg::entry_t   tbl_wr_data;

	logic               div_start;
	logic               div_done;
	logic [IVW-1:0]     div_quo;

	logic               in_acc;
	logic               out_free;
	logic [CMPW-1:0]    sel_ext;
	logic [CMPW-1:0]    cnt_ext;
	logic [IW-1:0]      sel_addr;
	logic               scan_last;
	logic [RTW-1:0]     charge;
	wvtp_pkg::entry_t   ins_entry;
	wvtp_pkg::entry_t   upd_entry;

	// Handshake terms.
	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != wvtp_pkg::SEQ_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// Slot compares and addresses at a common width.
	assign sel_ext   = CMPW'(sel_q);
	assign cnt_ext   = CMPW'(count_q);
	assign sel_addr  = sel_ext[IW-1:0];
	assign scan_last = (CW'(idx_q) == (count_q - CW'(1)));

	// Weighted charge: (delta * 1024 * inverse) >> INVERSE_SHIFT from the registered product.
	assign charge = RTW'({prod_q, {wvtp_pkg::UNIT_SHIFT{1'b0}}} >> INVERSE_SHIFT);

	// New row for an insert.
	always_comb begin
		ins_entry.runtime = '0;
		ins_entry.weight  = weight_q;
		ins_entry.inverse = div_quo;
		ins_entry.count   = '0;
	end

	// Updated row of the picked task.
	always_comb begin
		upd_entry = tbl_rd_data;
		if (tbl_rd_data.weight == WW'(wvtp_pkg::UNIT_WEIGHT)) begin
			upd_entry.runtime = tbl_rd_data.runtime + RTW'(tick_delta_q);
		end else begin
			upd_entry.runtime = tbl_rd_data.runtime + charge;
		end
		upd_entry.count = tbl_rd_data.count + 1'b1;
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wvtp_pkg::SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state and table and divider controls.
	always_comb begin
		state_d     = state_q;
		tbl_rd_en   = 1'b0;
		tbl_rd_addr = sel_addr;
		tbl_wr_en   = 1'b0;
		tbl_wr_addr = best_q;
		tbl_wr_data = upd_entry;
		div_start   = 1'b0;
		case (state_q)
			wvtp_pkg::SEQ_IDLE: begin
				if (in_acc) begin
					state_d = wvtp_pkg::SEQ_DECODE;
				end
			end
			wvtp_pkg::SEQ_DECODE: begin
				case (func_q)
					wvtp_pkg::FUNC_INSERT: begin
						if (count_q == CW'(MAX_TASKS)) begin
							state_d = wvtp_pkg::SEQ_REPLY;
						end else begin
							div_start = 1'b1;
							state_d   = wvtp_pkg::SEQ_DIV;
						end
					end
					wvtp_pkg::FUNC_TICK: begin
						if (count_q == '0) begin
							state_d = wvtp_pkg::SEQ_REPLY;
						end else begin
							state_d = wvtp_pkg::SEQ_SCAN_RD;
						end
					end
					wvtp_pkg::FUNC_READ: begin
						tbl_rd_en = 1'b1;
						if (sel_ext >= cnt_ext) begin
							state_d = wvtp_pkg::SEQ_REPLY;
						end else begin
							state_d = wvtp_pkg::SEQ_READ;
						end
					end
					default: begin
						state_d = wvtp_pkg::SEQ_IDLE;
					end
				endcase
			end
			wvtp_pkg::SEQ_DIV: begin
				if (div_done) begin
					tbl_wr_en   = 1'b1;
					tbl_wr_addr = count_q[IW-1:0];
					tbl_wr_data = ins_entry;
					state_d     = wvtp_pkg::SEQ_REPLY;
				end
			end
			wvtp_pkg::SEQ_SCAN_RD: begin
				tbl_rd_en   = 1'b1;
				tbl_rd_addr = idx_q;
				state_d     = wvtp_pkg::SEQ_SCAN_CMP;
			end
			wvtp_pkg::SEQ_SCAN_CMP: begin
				state_d = scan_last ? wvtp_pkg::SEQ_FETCH : wvtp_pkg::SEQ_SCAN_RD;
			end
			wvtp_pkg::SEQ_FETCH: begin
				tbl_rd_en   = 1'b1;
				tbl_rd_addr = best_q;
				state_d     = wvtp_pkg::SEQ_MUL;
			end
			wvtp_pkg::SEQ_MUL: begin
				state_d = wvtp_pkg::SEQ_UPDATE;
			end
			wvtp_pkg::SEQ_UPDATE: begin
				tbl_wr_en = 1'b1;
				state_d   = wvtp_pkg::SEQ_REPLY;
			end
			wvtp_pkg::SEQ_READ: begin
				state_d = wvtp_pkg::SEQ_REPLY;
			end
			wvtp_pkg::SEQ_REPLY: begin
				if (out_free) begin
					state_d = wvtp_pkg::SEQ_IDLE;
				end
			end
			default: begin
				state_d = wvtp_pkg::SEQ_IDLE;
			end
		endcase
	end

	// Control registers: task count, configuration and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			tick_delta_q <= wvtp_pkg::DELTA_RESET;
			inv_num_q    <= wvtp_pkg::NUM_RESET;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == wvtp_pkg::SEQ_DIV && div_done) begin
				count_q <= count_q + 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				case (wvtp_pkg::cfg_reg_t'(cfg_index))
					wvtp_pkg::REG_TICK_DELTA: tick_delta_q <= cfg_data[DLW-1:0];
					wvtp_pkg::REG_INV_NUM:    inv_num_q    <= cfg_data[IVW-1:0];
					default: ;
				endcase
			end
			if (state_q == wvtp_pkg::SEQ_REPLY && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item, scan and result registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q   <= wvtp_pkg::func_t'(func);
			weight_q <= weight;
			sel_q    <= slot_select;
		end
		case (state_q)
			wvtp_pkg::SEQ_DECODE: begin
				idx_q         <= '0;
				res_q.slot    <= (func_q == wvtp_pkg::FUNC_READ) ? SLW'(sel_q) : '0;
				res_q.runtime <= '0;
				res_q.count   <= '0;
				res_q.weight  <= '0;
				case (func_q)
					wvtp_pkg::FUNC_INSERT: res_q.status <= wvtp_pkg::STAT_FULL;
					wvtp_pkg::FUNC_TICK:   res_q.status <= wvtp_pkg::STAT_NO_TASKS;
					default:               res_q.status <= wvtp_pkg::STAT_BAD_SLOT;
				endcase
			end
			wvtp_pkg::SEQ_DIV: begin
				if (div_done) begin
					res_q.status  <= wvtp_pkg::STAT_OK;
					res_q.slot    <= SLW'(count_q);
					res_q.runtime <= '0;
					res_q.count   <= '0;
					res_q.weight  <= weight_q;
				end
			end
			wvtp_pkg::SEQ_SCAN_CMP: begin
				if (idx_q == '0 || tbl_rd_data.runtime < best_rt_q) begin
					best_q    <= idx_q;
					best_rt_q <= tbl_rd_data.runtime;
				end
				idx_q <= idx_q + 1'b1;
			end
			wvtp_pkg::SEQ_MUL: begin
				prod_q <= PROD_W'(tick_delta_q) * PROD_W'(tbl_rd_data.inverse);
			end
			wvtp_pkg::SEQ_UPDATE: begin
				res_q.status  <= wvtp_pkg::STAT_OK;
				res_q.slot    <= SLW'(best_q);
				res_q.runtime <= upd_entry.runtime;
				res_q.count   <= upd_entry.count;
				res_q.weight  <= upd_entry.weight;
			end
			wvtp_pkg::SEQ_READ: begin
				res_q.status  <= wvtp_pkg::STAT_OK;
				res_q.slot    <= SLW'(sel_q);
				res_q.runtime <= tbl_rd_data.runtime;
				res_q.count   <= tbl_rd_data.count;
				res_q.weight  <= tbl_rd_data.weight;
			end
			wvtp_pkg::SEQ_REPLY: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	// Output port.
	assign out_valid       = out_valid_q;
	assign status          = out_q.status;
	assign task_slot       = out_q.slot;
	assign virtual_runtime = out_q.runtime;
	assign run_count       = out_q.count;
	assign task_weight     = out_q.weight;

	wvtp_task_table #(
		.MAX_TASKS (MAX_TASKS)
	) u_table (
		.clk     (clk),
		.rd_en   (tbl_rd_en),
		.rd_addr (tbl_rd_addr),
		.rd_data (tbl_rd_data),
		.wr_en   (tbl_wr_en),
		.wr_addr (tbl_wr_addr),
		.wr_data (tbl_wr_data)
	);

	wvtp_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (inv_num_q),
		.divisor  (weight_q),
		.done     (div_done),
		.quotient (div_quo)
	);

`ifndef SYNTHESIS
	// The task count never passes the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(count_q) <= CMPW'(MAX_TASKS))
		else $error("task count exceeds table depth");

	// The divider finishes only while the sequencer waits for it.
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == wvtp_pkg::SEQ_DIV))
		else $error("divider finished outside the insert wait");

	// The table is written only by an insert or a tick update.
	a_table_write: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_wr_en |-> (state_q == wvtp_pkg::SEQ_DIV || state_q == wvtp_pkg::SEQ_UPDATE))
		else $error("table written outside insert or update");

	// The scan only compares slots that hold tasks.
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wvtp_pkg::SEQ_SCAN_CMP) |-> (CW'(idx_q) < count_q))
		else $error("scan index beyond the stored tasks");

	// A new result appears only after the reply state transfers it.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == wvtp_pkg::SEQ_REPLY))
		else $error("result appeared without a reply");
`endif

endmodule

// ===== tb/weighted_vruntime_task_picker_core_test.sv =====
// Self-checking testbench for the weighted virtual-runtime task picker core.
`timescale 1ns / 1ps

module weighted_vruntime_task_picker_core_test;

	localparam int FUNC_W      = wvtp_pkg::FUNC_W;
	localparam int WEIGHT_W    = wvtp_pkg::WEIGHT_W;
	localparam int SEL_W       = wvtp_pkg::SEL_W;
	localparam int STATUS_W    = wvtp_pkg::STATUS_W;
	localparam int SLOT_W      = wvtp_pkg::SLOT_W;
	localparam int RT_W        = wvtp_pkg::RT_W;
	localparam int CNT_W       = wvtp_pkg::CNT_W;
	localparam int INV_W       = wvtp_pkg::INV_W;
	localparam int DELTA_W     = wvtp_pkg::DELTA_W;
	localparam int CFG_IDX_W   = wvtp_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W  = wvtp_pkg::CFG_DATA_W;
	localparam int UNIT_WEIGHT = wvtp_pkg::UNIT_WEIGHT;

	localparam int SLOTS       = wvtp_pkg::MAX_TASKS_DEF;
	localparam int SHIFT       = wvtp_pkg::INVERSE_SHIFT_DEF;
	localparam int SETTLE      = 60;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 130;
	localparam int PRINT_CAP   = 40;
	localparam logic [WEIGHT_W-1:0] MAX_WEIGHT = '1;
	localparam logic [DELTA_W-1:0]  MAX_DELTA  = '1;

	// Task table predictor with the queue of results it expects from the block.
	class picker_scoreboard;
		logic [DELTA_W-1:0]  delta;
		logic [INV_W-1:0]    numerator;
		int                  used;
		logic [RT_W-1:0]     vruntime [SLOTS];
		logic [WEIGHT_W-1:0] load [SLOTS];
		logic [INV_W-1:0]    inverse [SLOTS];
		logic [CNT_W-1:0]    runs [SLOTS];
		wvtp_pkg::result_t   pending [$];
		int                  errors;
		int                  checked;
		int                  inserts;
		int                  full_hits;
		int                  ticks;
		int                  reads;

		function new();
			delta     = wvtp_pkg::DELTA_RESET;
			numerator = wvtp_pkg::NUM_RESET;
			used      = 0;
			errors    = 0;
			checked   = 0;
			inserts   = 0;
			full_hits = 0;
			ticks     = 0;
			reads     = 0;
		endfunction

		function void set_register(wvtp_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				wvtp_pkg::REG_TICK_DELTA: delta = data[DELTA_W-1:0];
				wvtp_pkg::REG_INV_NUM:    numerator = data[INV_W-1:0];
				default: ;
			endcase
		endfunction

		// A unit-weight task is charged the plain delta, any other the scaled one.
		function logic [RT_W-1:0] charge(int k);
			logic [RT_W-1:0] prod;
			if (load[k] == WEIGHT_W'(UNIT_WEIGHT))
				return RT_W'(delta);
			prod = RT_W'(delta) * RT_W'(UNIT_WEIGHT) * RT_W'(inverse[k]);
			return prod >> SHIFT;
		endfunction

		// Updates the table for one accepted transfer and queues its result.
		function void note_item(wvtp_pkg::func_t op, logic [WEIGHT_W-1:0] w,
			logic [SEL_W-1:0] sel);
			wvtp_pkg::result_t r;
			int                best;
			r = '0;
			r.status = wvtp_pkg::STAT_OK;
			case (op)
				wvtp_pkg::FUNC_INSERT: begin
					inserts++;
					if (used >= SLOTS) begin
						r.status = wvtp_pkg::STAT_FULL;
						full_hits++;
					end else begin
						load[used]     = w;
						inverse[used]  = (w == 0) ? '1 : numerator / INV_W'(w);
						vruntime[used] = '0;
						runs[used]     = '0;
						r.slot   = SLOT_W'(used);
						r.weight = w;
						used++;
					end
					pending.push_back(r);
				end
				wvtp_pkg::FUNC_TICK: begin
					ticks++;
					if (used == 0) begin
						r.status = wvtp_pkg::STAT_NO_TASKS;
					end else begin
						// Least runtime wins; the strict compare keeps the lowest slot on ties.
						best = 0;
						for (int k = 1; k < used; k++)
							if (vruntime[k] < vruntime[best])
								best = k;
						vruntime[best] += charge(best);
						runs[best]     += 1;
						r.slot    = SLOT_W'(best);
						r.runtime = vruntime[best];
						r.count   = runs[best];
						r.weight  = load[best];
					end
					pending.push_back(r);
				end
				wvtp_pkg::FUNC_READ: begin
					reads++;
					r.slot = sel;
					if (sel >= used) begin
						r.status = wvtp_pkg::STAT_BAD_SLOT;
					end else begin
						r.runtime = vruntime[sel];
						r.count   = runs[sel];
						r.weight  = load[sel];
					end
					pending.push_back(r);
				end
				default: begin
					// The unused code produces no result.
				end
			endcase
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= PRINT_CAP)
				$display("mismatch at %0t ns: %s", $time, what);
		endtask

		task check_result(wvtp_pkg::result_t got);
			wvtp_pkg::result_t want;
			if (pending.size() == 0) begin
				report_mismatch("result transfer with no result outstanding");
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.status !== want.status)
				report_mismatch($sformatf("field status got %0d want %0d",
					got.status, want.status));
			if (got.slot !== want.slot)
				report_mismatch($sformatf("task_slot got %0d want %0d", got.slot, want.slot));
			if (got.runtime !== want.runtime)
				report_mismatch($sformatf("virtual_runtime got %h want %h",
					got.runtime, want.runtime));
			if (got.count !== want.count)
				report_mismatch($sformatf("run_count got %0d want %0d", got.count, want.count));
			if (got.weight !== want.weight)
				report_mismatch($sformatf("task_weight got %0d want %0d",
					got.weight, want.weight));
		endtask
	endclass

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_valid   = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic [FUNC_W-1:0]     func        = '0;
	logic [WEIGHT_W-1:0]   weight      = '0;
	logic [SEL_W-1:0]      slot_select = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [SLOT_W-1:0]     task_slot;
	logic [RT_W-1:0]       virtual_runtime;
	logic [CNT_W-1:0]      run_count;
	logic [WEIGHT_W-1:0]   task_weight;

	picker_scoreboard sb = new();
	bit               steady = 1'b0;
	int               stall_left = 0;
	int               settings = 1;

	weighted_vruntime_task_picker_core i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.weight          (weight),
		.slot_select     (slot_select),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.task_slot       (task_slot),
		.virtual_runtime (virtual_runtime),
		.run_count       (run_count),
		.task_weight     (task_weight)
	);

	always #5 clk = ~clk;

	// Idle stretch length: mostly none, often short, now and then long.
	function automatic int idle_length();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Half the time a corner weight, otherwise any 17-bit value.
	function automatic logic [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return WEIGHT_W'(1);
			2: return WEIGHT_W'(UNIT_WEIGHT);
			3: return MAX_WEIGHT;
			default: return WEIGHT_W'($urandom);
		endcase
	endfunction

	// Result side: check each transfer, then decide the stall for the next cycle.
	always @(posedge clk) begin : watch_results
		wvtp_pkg::result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.status  = wvtp_pkg::status_t'(status);
			got.slot    = task_slot;
			got.runtime = virtual_runtime;
			got.count   = run_count;
			got.weight  = task_weight;
			sb.check_result(got);
		end
		if (stall_left > 0)
			stall_left--;
		else
			stall_left = idle_length();
		out_stall <= (stall_left > 0);
	end

	task automatic write_register(wvtp_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_register(idx, data);
	endtask

	// Presents one item and returns at the edge where it is transferred.
	task automatic send_item(wvtp_pkg::func_t op, logic [WEIGHT_W-1:0] w,
		logic [SEL_W-1:0] sel);
		int gap;
		gap = idle_length();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= op;
		weight      <= w;
		slot_select <= sel;
		do @(posedge clk); while (in_stall);
		sb.note_item(op, w, sel);
	endtask

	// Holds off the sender until every result is back and the block has gone quiet.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// One random phase with exactly the given number of insert items.
	task automatic run_phase(int count, int quota);
		int left;
		left = count;
		while (left > 0) begin
			if ($urandom_range(0, 19) == 0) begin
				send_item(wvtp_pkg::FUNC_NOP, WEIGHT_W'($urandom), SEL_W'($urandom));
				continue;
			end
			if (quota > 0 && $urandom_range(1, left) <= quota) begin
				send_item(wvtp_pkg::FUNC_INSERT, pick_weight(), SEL_W'($urandom));
				quota--;
			end else if ($urandom_range(0, 99) < 62) begin
				send_item(wvtp_pkg::FUNC_TICK, WEIGHT_W'($urandom), SEL_W'($urandom));
			end else begin
				send_item(wvtp_pkg::FUNC_READ, WEIGHT_W'($urandom), SEL_W'($urandom));
			end
			left--;
		end
	endtask

	initial begin : stimulus
		int                    insert_quota [PHASES];
		logic [CFG_DATA_W-1:0] delta_value;
		logic [CFG_DATA_W-1:0] num_value;

		// Inserts are rationed so the table fills only in the last phase, where a
		// numerator of one gives zero inverses for weights above one and the remaining inserts find it full.
		insert_quota = '{2, 2, 2, 2, 1, 1, 0, 6};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening with the reset register values.
		send_item(wvtp_pkg::FUNC_TICK, '0, '0);
		send_item(wvtp_pkg::FUNC_READ, '0, '0);
		send_item(wvtp_pkg::FUNC_READ, MAX_WEIGHT, '1);
		send_item(wvtp_pkg::FUNC_NOP, '0, '0);
		send_item(wvtp_pkg::FUNC_INSERT, WEIGHT_W'(UNIT_WEIGHT), '0);
		send_item(wvtp_pkg::FUNC_READ, '0, SEL_W'(1));
		send_item(wvtp_pkg::FUNC_TICK, '0, '0);
		send_item(wvtp_pkg::FUNC_INSERT, '0, '1);
		send_item(wvtp_pkg::FUNC_INSERT, MAX_WEIGHT, '0);
		send_item(wvtp_pkg::FUNC_INSERT, WEIGHT_W'(1), '0);
		send_item(wvtp_pkg::FUNC_TICK, MAX_WEIGHT, '1);
		send_item(wvtp_pkg::FUNC_TICK, '0, '0);
		send_item(wvtp_pkg::FUNC_TICK, '0, '0);
		send_item(wvtp_pkg::FUNC_TICK, '0, '0);
		send_item(wvtp_pkg::FUNC_READ, '0, '0);
		send_item(wvtp_pkg::FUNC_READ, '0, SEL_W'(3));
		send_item(wvtp_pkg::FUNC_READ, '0, SEL_W'(2));
		send_item(wvtp_pkg::FUNC_READ, '0, SEL_W'(4));
		send_item(wvtp_pkg::FUNC_NOP, MAX_WEIGHT, '1);
		drain();

		// Random phases, each under its own register setting.
		for (int p = 0; p < PHASES; p++) begin
			delta_value = CFG_DATA_W'(DELTA_W'($urandom));
			num_value   = $urandom | 32'h0002_0000;
			if (p == 0) begin
				delta_value = CFG_DATA_W'(MAX_DELTA);
			end else if (p == 1) begin
				delta_value = '0;
				num_value   = wvtp_pkg::NUM_RESET;
			end else if (p == PHASES - 1) begin
				num_value = CFG_DATA_W'(1);
			end
			write_register(wvtp_pkg::REG_TICK_DELTA, delta_value);
			write_register(wvtp_pkg::REG_INV_NUM, num_value);
			settings++;
			steady = (p == 3);
			run_phase(PHASE_ITEMS, insert_quota[p]);
			drain();
		end

		$display("covered %0d inserts (%0d into a full table), %0d ticks and %0d reads",
			sb.inserts, sb.full_hits, sb.ticks, sb.reads);
		$display("%0d results checked under %0d register settings, %0d mismatches",
			sb.checked, settings, sb.errors);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#10ms;
		$display("timeout with %0d results outstanding", sb.pending.size());
		$display("status: fail");
		$finish;
	end

endmodule

// ===== weighted_vruntime_task_picker_core.f =====
design/wvtp_pkg.sv
design/wvtp_divider.sv
design/wvtp_task_table.sv
design/weighted_vruntime_task_picker_core.sv
tb/weighted_vruntime_task_picker_core_test.sv
